/* design/b3atr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b3atr_pkg
// Shared constants, register codes and width helpers for the B3-spline
// a trous row filter.
// ----------------------------------------------------------------------------
package b3atr_pkg;

  localparam int unsigned MAX_ROW_LENGTH_DEF = 1024;
  localparam int unsigned MAX_STEP_SHIFT_DEF = 4;
  localparam int unsigned SAMPLE_WIDTH_DEF   = 24;

  localparam int unsigned ROW_LEN_W    = 11;
  localparam int unsigned NUM_ROWS_W   = 17;
  localparam int unsigned STEP_SHIFT_W = 3;
  localparam int unsigned CFG_DATA_W   = 17;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned ROW_W        = 16;

  // entries in the queue between front and back end
  localparam int unsigned JOB_Q_DEPTH = 4;

  localparam logic [ROW_LEN_W-1:0]    ROW_LENGTH_RST = 11'd1024;
  localparam logic [NUM_ROWS_W-1:0]   NUM_ROWS_RST   = 17'd1;
  localparam logic [STEP_SHIFT_W-1:0] STEP_SHIFT_RST = 3'd0;
  localparam logic [NUM_ROWS_W-1:0]   MAX_ROWS       = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH = 2'd0,
    CFG_NUM_ROWS   = 2'd1,
    CFG_STEP_SHIFT = 2'd2
  } cfg_reg_t;

  // bits for a column or an effective row length (may be raised to 4*step+1)
  function automatic int unsigned len_w(int unsigned max_len, int unsigned max_shift);
    int unsigned span;
    span = 4 * (1 << max_shift) + 1;
    return $clog2(((max_len > span) ? max_len : span) + 1);
  endfunction

  // window address bits: kernel span, one flush run of new-row samples and
  // every queued entry must fit without overwriting a tap still to be read
  function automatic int unsigned win_addr_w(int unsigned max_shift);
    return $clog2(6 * (1 << max_shift) + JOB_Q_DEPTH + 2);
  endfunction

  function automatic int unsigned job_w(int unsigned max_len, int unsigned max_shift);
    return win_addr_w(max_shift) + 2 * len_w(max_len, max_shift) + (max_shift + 1)
           + ROW_W + 3;
  endfunction

endpackage

/* design/b3_spline_atrous_row_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b3_spline_atrous_row_filter
// Row filter with the dilated B3-spline kernel (1 4 6 4 1)/16 and mirrored
// borders. Every result carries its position and row for a transposed store.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-----------------
//   input   | in_sample                               | in_valid/in_ready
//   result  | out_value, out_position, out_row_index, | out_valid/out_ready
//           | out_last_in_run, out_last_of_image      |
//   config  | cfg_index, cfg_data                     | cfg_we, no wait
//
// a sample that causes no result is written to the window and queues no job
// each result takes five window reads through the single read port, the last
// add and the output register in the back end, after its job is taken when idle
// the last sample of a row causes 2*step+1 results, the others at most one
// input stalls when the four-entry job queue is full or a register is written
// synchronous active-low reset; window memory needs no clearing pass
// ----------------------------------------------------------------------------
module b3_spline_atrous_row_filter import b3atr_pkg::*; #(
  parameter int unsigned MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF,
  parameter int unsigned MAX_STEP_SHIFT = MAX_STEP_SHIFT_DEF,
  parameter int unsigned SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  localparam int unsigned POS_W = $clog2(MAX_ROW_LENGTH)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SAMPLE_WIDTH-1:0] out_value,
  output logic [POS_W-1:0]        out_position,
  output logic [ROW_W-1:0]        out_row_index,
  output logic                    out_last_in_run,
  output logic                    out_last_of_image
);

  localparam int unsigned WAW   = win_addr_w(MAX_STEP_SHIFT);
  localparam int unsigned JOB_W = job_w(MAX_ROW_LENGTH, MAX_STEP_SHIFT);

  logic                    q_full;
  logic                    q_empty;
  logic                    q_push;
  logic                    q_pop;
  logic [JOB_W-1:0]        q_job_in;
  logic [JOB_W-1:0]        q_job_out;
  logic                    mem_we;
  logic [WAW-1:0]          mem_waddr;
  logic [SAMPLE_WIDTH-1:0] mem_wdata;

  b3atr_front #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
    .MAX_STEP_SHIFT (MAX_STEP_SHIFT),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job_in),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  b3atr_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_Q_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_job_in),
    .pop   (q_pop),
    .dout  (q_job_out),
    .empty (q_empty),
    .full  (q_full)
  );

  b3atr_back #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
    .MAX_STEP_SHIFT (MAX_STEP_SHIFT),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .q_empty           (q_empty),
    .q_job             (q_job_out),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value         (out_value),
    .out_position      (out_position),
    .out_row_index     (out_row_index),
    .out_last_in_run   (out_last_in_run),
    .out_last_of_image (out_last_of_image)
  );

  // the end of an image is always the end of a flush run
  a_image_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_image |-> out_last_in_run)
    else $error("last_of_image without last_in_run");

  // results of one run all belong to the same row
  a_run_keeps_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_in_run |=> $stable(out_row_index))
    else $error("row index changed inside a run");

  // the front end must never push into a full job queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

endmodule

/* design/b3atr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b3atr_fifo
// Small first-in first-out queue of filter jobs between front and back end.
// ----------------------------------------------------------------------------
module b3atr_fifo import b3atr_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = JOB_Q_DEPTH,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    rd_ptr_r;
  logic [AW-1:0]    wr_ptr_r;
  logic [CNTW-1:0]  cnt_r;
  logic             do_push;
  logic             do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNTW'(DEPTH));
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* design/b3atr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b3atr_front
// Configuration registers, column and row tracking. Writes each sample into
// the window and queues a job for every sample that causes results.
// ----------------------------------------------------------------------------
module b3atr_front import b3atr_pkg::*; #(
  parameter int unsigned MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF,
  parameter int unsigned MAX_STEP_SHIFT = MAX_STEP_SHIFT_DEF,
  parameter int unsigned SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  localparam int unsigned LW    = len_w(MAX_ROW_LENGTH, MAX_STEP_SHIFT),
  localparam int unsigned SHW   = MAX_STEP_SHIFT + 1,
  localparam int unsigned WAW   = win_addr_w(MAX_STEP_SHIFT),
  localparam int unsigned JOB_W = job_w(MAX_ROW_LENGTH, MAX_STEP_SHIFT)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                    q_full,
  output logic                    q_push,
  output logic [JOB_W-1:0]        q_job,
  output logic                    mem_we,
  output logic [WAW-1:0]          mem_waddr,
  output logic [SAMPLE_WIDTH-1:0] mem_wdata
);

  typedef struct packed {
    logic [WAW-1:0]   ptr;
    logic [LW-1:0]    col;
    logic [SHW-1:0]   step;
    logic [LW-1:0]    len;
    logic [ROW_W-1:0] row;
    logic             last_row;
    logic             emit_main;
    logic             end_row;
  } job_t;

  logic [ROW_LEN_W-1:0]    row_length_r;
  logic [NUM_ROWS_W-1:0]   num_rows_r;
  logic [STEP_SHIFT_W-1:0] step_shift_r;
  logic [LW-1:0]           col_r;
  logic [ROW_W-1:0]        row_r;
  logic [WAW-1:0]          ptr_r;

  logic [STEP_SHIFT_W-1:0] shift_sat;
  logic [SHW-1:0]          step;
  logic [31:0]             len_sat;
  logic [31:0]             len_min;
  logic [31:0]             len32;
  logic [LW-1:0]           len;
  logic [NUM_ROWS_W-1:0]   rows_eff;
  logic [NUM_ROWS_W-1:0]   row_inc;
  logic                    last_row;
  logic                    end_row;
  logic                    emit_main;
  logic                    accept;
  job_t                    job_d;

  always_comb begin
    shift_sat = (32'(step_shift_r) > MAX_STEP_SHIFT) ? STEP_SHIFT_W'(MAX_STEP_SHIFT)
                                                     : step_shift_r;
    step      = SHW'(1) << shift_sat;
    len_sat   = (32'(row_length_r) > MAX_ROW_LENGTH) ? 32'(MAX_ROW_LENGTH)
                                                     : 32'(row_length_r);
    len_min   = (32'(step) << 2) + 32'd1;
    len32     = (len_sat < len_min) ? len_min : len_sat;
    len       = len32[LW-1:0];

    if (num_rows_r == '0) begin
      rows_eff = NUM_ROWS_W'(1);
    end else if (num_rows_r > MAX_ROWS) begin
      rows_eff = MAX_ROWS;
    end else begin
      rows_eff = num_rows_r;
    end
    row_inc   = {1'b0, row_r} + 1'b1;
    last_row  = (row_inc >= rows_eff);
    end_row   = (col_r >= len - 1'b1);
    emit_main = (col_r >= (LW'(step) << 1));
  end

  // no transfer while a register is being written
  assign in_ready  = !q_full && !cfg_we;
  assign accept    = in_valid && in_ready;
  assign mem_we    = accept;
  assign mem_waddr = ptr_r;
  assign mem_wdata = in_sample;
  assign q_push    = accept && (emit_main || end_row);

  always_comb begin
    job_d.ptr       = ptr_r;
    job_d.col       = col_r;
    job_d.step      = step;
    job_d.len       = len;
    job_d.row       = row_r;
    job_d.last_row  = last_row;
    job_d.emit_main = emit_main;
    job_d.end_row   = end_row;
  end

  assign q_job = job_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= ROW_LENGTH_RST;
      num_rows_r   <= NUM_ROWS_RST;
      step_shift_r <= STEP_SHIFT_RST;
      col_r        <= '0;
      row_r        <= '0;
      ptr_r        <= '0;
    end else if (cfg_we) begin
      // a new length or spacing restarts the current row
      unique case (cfg_index)
        CFG_ROW_LENGTH: begin
          row_length_r <= cfg_data[ROW_LEN_W-1:0];
          col_r        <= '0;
        end
        CFG_NUM_ROWS: begin
          num_rows_r <= cfg_data[NUM_ROWS_W-1:0];
        end
        CFG_STEP_SHIFT: begin
          step_shift_r <= cfg_data[STEP_SHIFT_W-1:0];
          col_r        <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      ptr_r <= ptr_r + 1'b1;
      if (end_row) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

endmodule

/* design/b3atr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b3atr_back
// Sample window memory and filter engine. Takes queued jobs and produces
// each result from five window reads through one read port.
// ----------------------------------------------------------------------------
module b3atr_back import b3atr_pkg::*; #(
  parameter int unsigned MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF,
  parameter int unsigned MAX_STEP_SHIFT = MAX_STEP_SHIFT_DEF,
  parameter int unsigned SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  localparam int unsigned LW    = len_w(MAX_ROW_LENGTH, MAX_STEP_SHIFT),
  localparam int unsigned SHW   = MAX_STEP_SHIFT + 1,
  localparam int unsigned WAW   = win_addr_w(MAX_STEP_SHIFT),
  localparam int unsigned JOB_W = job_w(MAX_ROW_LENGTH, MAX_STEP_SHIFT),
  localparam int unsigned POS_W = $clog2(MAX_ROW_LENGTH)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    mem_we,
  input  logic [WAW-1:0]          mem_waddr,
  input  logic [SAMPLE_WIDTH-1:0] mem_wdata,
  input  logic                    q_empty,
  input  logic [JOB_W-1:0]        q_job,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SAMPLE_WIDTH-1:0] out_value,
  output logic [POS_W-1:0]        out_position,
  output logic [ROW_W-1:0]        out_row_index,
  output logic                    out_last_in_run,
  output logic                    out_last_of_image
);

  localparam int unsigned TW    = LW + 2;
  localparam int unsigned ACC_W = SAMPLE_WIDTH + 4;
  localparam int unsigned DEPTH = 1 << WAW;

  localparam logic [2:0] TAP_FAR_L  = 3'd0;
  localparam logic [2:0] TAP_NEAR_L = 3'd1;
  localparam logic [2:0] TAP_CENTRE = 3'd2;
  localparam logic [2:0] TAP_NEAR_R = 3'd3;
  localparam logic [2:0] TAP_FAR_R  = 3'd4;

  typedef struct packed {
    logic [WAW-1:0]   ptr;
    logic [LW-1:0]    col;
    logic [SHW-1:0]   step;
    logic [LW-1:0]    len;
    logic [ROW_W-1:0] row;
    logic             last_row;
    logic             emit_main;
    logic             end_row;
  } job_t;

  typedef enum logic [1:0] {S_IDLE, S_TAP, S_LAST, S_OUT} state_t;

  logic [SAMPLE_WIDTH-1:0] win_mem [DEPTH];
  logic [SAMPLE_WIDTH-1:0] rd_data_r;
  logic [WAW-1:0]          rd_addr;

  state_t                  state_r;
  job_t                    job_r;
  job_t                    head;
  logic [LW-1:0]           x_r;
  logic                    flush_r;
  logic [2:0]              k_r;
  logic                    pend_r;
  logic [2:0]              pend_k_r;
  logic [ACC_W-1:0]        sum_r;
  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] out_value_r;
  logic [POS_W-1:0]        out_position_r;
  logic [ROW_W-1:0]        out_row_index_r;
  logic                    out_last_in_run_r;
  logic                    out_last_of_image_r;

  logic signed [TW-1:0]    t_s;
  logic signed [TW-1:0]    r_s;
  logic [TW-1:0]           col_back;
  logic [ACC_W-1:0]        rd_ext;
  logic [ACC_W-1:0]        wdata;
  logic [ACC_W-1:0]        sum_rnd;
  logic [LW-1:0]           two_step;
  logic                    last_out;
  logic                    slot_free;

  assign head = q_job;

  // window memory: one write port from the front end, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= win_mem[rd_addr];
  end

  // tap column with half-sample mirroring, then its place in the window
  always_comb begin
    t_s = signed'(TW'(x_r)) + signed'(TW'(k_r) * TW'(job_r.step))
          - signed'(TW'({job_r.step, 1'b0}));
    if (t_s < 0) begin
      r_s = -t_s - TW'(1);
    end else if (t_s >= signed'(TW'(job_r.len))) begin
      r_s = signed'(TW'({job_r.len, 1'b0})) - t_s - TW'(1);
    end else begin
      r_s = t_s;
    end
    if (r_s < 0) begin
      r_s = '0;
    end
    col_back = TW'(job_r.col) - TW'(r_s);
    rd_addr  = job_r.ptr - col_back[WAW-1:0];
  end

  // kernel weights 1 4 6 4 1 as shifts and adds
  always_comb begin
    rd_ext = ACC_W'(rd_data_r);
    case (pend_k_r) inside
      TAP_FAR_L, TAP_FAR_R:   wdata = rd_ext;
      TAP_NEAR_L, TAP_NEAR_R: wdata = rd_ext << 2;
      TAP_CENTRE:             wdata = (rd_ext << 2) + (rd_ext << 1);
      default:                wdata = '0;
    endcase
  end

  always_comb begin
    two_step  = LW'({job_r.step, 1'b0});
    last_out  = flush_r ? (x_r == job_r.len - 1'b1) : !job_r.end_row;
    sum_rnd   = sum_r + ACC_W'(8);
    slot_free = !out_valid_r || out_ready;
  end

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= TAP_FAR_L;
      pend_r      <= 1'b0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_OUT a new result takes the place of the one leaving
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            job_r   <= head;
            flush_r <= !head.emit_main;
            x_r     <= head.emit_main ? head.col - LW'({head.step, 1'b0})
                                      : head.len - LW'({head.step, 1'b0});
            k_r     <= TAP_FAR_L;
            sum_r   <= '0;
            state_r <= S_TAP;
          end
        end
        S_TAP: begin
          // read data is registered and arrives in the cycle after its address
          if (pend_r) begin
            sum_r <= sum_r + wdata;
          end
          pend_r   <= 1'b1;
          pend_k_r <= k_r;
          if (k_r == TAP_FAR_R) begin
            state_r <= S_LAST;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_LAST: begin
          sum_r   <= sum_r + wdata;
          pend_r  <= 1'b0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            out_valid_r         <= 1'b1;
            out_value_r         <= sum_rnd[ACC_W-1:4];
            out_position_r      <= x_r[POS_W-1:0];
            out_row_index_r     <= job_r.row;
            out_last_in_run_r   <= last_out;
            out_last_of_image_r <= job_r.last_row && (x_r == job_r.len - 1'b1);
            sum_r               <= '0;
            k_r                 <= TAP_FAR_L;
            if (last_out) begin
              state_r <= S_IDLE;
            end else begin
              x_r     <= flush_r ? x_r + 1'b1 : job_r.len - two_step;
              flush_r <= 1'b1;
              state_r <= S_TAP;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value         = out_value_r;
  assign out_position      = out_position_r;
  assign out_row_index     = out_row_index_r;
  assign out_last_in_run   = out_last_in_run_r;
  assign out_last_of_image = out_last_of_image_r;

endmodule

/* tb/b3_spline_atrous_row_filter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b3_spline_atrous_row_filter_tb
// Streams rows of samples through the a trous row filter under several
// register settings and compares every filtered pixel, with its position,
// row and flags, against a cycle-free predictor of the dilated B3 kernel.
// Sender bursts and receiver stalls are random, with one long receiver
// hold-off that fills the block and one sender pause until it drains.
// ----------------------------------------------------------------------------
module b3_spline_atrous_row_filter_tb;
  import b3atr_pkg::*;

  localparam int unsigned POS_W        = $clog2(MAX_ROW_LENGTH_DEF);
  localparam int unsigned SW           = SAMPLE_WIDTH_DEF;
  localparam int unsigned WIN_DEPTH    = 4 * (1 << MAX_STEP_SHIFT_DEF) + 1;
  localparam int unsigned WIN_AW       = $clog2(WIN_DEPTH);
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned STALL_LIMIT  = 4000;

  // write to an index that has no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
  localparam logic [15:0] READY_BITS = 16'b1101_0110_0011_1011;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN
  } ready_mode_t;

  typedef struct packed {
    logic [SW-1:0]    value;
    logic [POS_W-1:0] position;
    logic [ROW_W-1:0] row_index;
    logic             last_in_run;
    logic             last_of_image;
  } filt_pixel_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SW-1:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SW-1:0] out_value;
  logic [POS_W-1:0] out_position;
  logic [ROW_W-1:0] out_row_index;
  logic out_last_in_run;
  logic out_last_of_image;

  b3_spline_atrous_row_filter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value        (out_value),
    .out_position     (out_position),
    .out_row_index    (out_row_index),
    .out_last_in_run  (out_last_in_run),
    .out_last_of_image(out_last_of_image)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [SW-1:0] row_window [WIN_DEPTH];
  logic [ROW_LEN_W-1:0] len_reg = ROW_LENGTH_RST;
  logic [NUM_ROWS_W-1:0] rows_reg = NUM_ROWS_RST;
  logic [STEP_SHIFT_W-1:0] shift_reg = STEP_SHIFT_RST;
  int unsigned next_col = 0;
  int unsigned cur_row = 0;

  filt_pixel_t expected_pixels[$];
  logic [SW-1:0] sample_feed[$];
  int unsigned fail_count = 0;
  logic in_accepted = 1'b0;

  // sender and receiver pacing
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int unsigned mode_left = 50;
  logic [3:0] pat_idx = '0;

  function automatic int unsigned tap_step(int unsigned shift);
    return 1 << ((shift > MAX_STEP_SHIFT_DEF) ? MAX_STEP_SHIFT_DEF : shift);
  endfunction

  function automatic int unsigned row_span(int unsigned len, int unsigned shift);
    int unsigned w;
    int unsigned step;
    step = tap_step(shift);
    w = (len > MAX_ROW_LENGTH_DEF) ? MAX_ROW_LENGTH_DEF : len;
    if (w < 4 * step + 1) w = 4 * step + 1;
    return w;
  endfunction

  // half-sample mirror at both ends of the row
  function automatic logic [SW-1:0] mirror_tap(int i, int w);
    if (i < 0) i = -i - 1;
    else if (i >= w) i = 2 * w - 1 - i;
    if (i < 0) i = 0;
    return row_window[WIN_AW'(i % WIN_DEPTH)];
  endfunction

  function automatic filt_pixel_t b3_pixel(int x, int step, int w, bit last_row,
                                           bit last_run);
    filt_pixel_t px;
    logic [31:0] a, b, c, d, e, acc;
    a = 32'(mirror_tap(x - 2 * step, w));
    b = 32'(mirror_tap(x - step, w));
    c = 32'(mirror_tap(x, w));
    d = 32'(mirror_tap(x + step, w));
    e = 32'(mirror_tap(x + 2 * step, w));
    acc = a + e + 4 * (b + d) + 6 * c + 8;
    px.value = acc[SW+3:4];
    px.position = x[POS_W-1:0];
    px.row_index = cur_row[ROW_W-1:0];
    px.last_in_run = last_run;
    px.last_of_image = last_row && (x == w - 1);
    return px;
  endfunction

  task automatic filter_sample(logic [SW-1:0] s);
    int unsigned step, w, nrows, c;
    int x;
    bit last_row, end_row;
    step = tap_step(shift_reg);
    w = row_span(len_reg, shift_reg);
    nrows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
    c = next_col;
    last_row = (cur_row + 1 >= nrows);
    end_row = (c >= w - 1);
    row_window[WIN_AW'(c % WIN_DEPTH)] = s;
    if (c >= 2 * step)
      expected_pixels.push_back(b3_pixel(c - 2 * step, step, w, last_row, !end_row));
    if (end_row) begin
      // flush of the right border
      for (x = w - 2 * step; x < w; x++)
        expected_pixels.push_back(b3_pixel(x, step, w, last_row, x == w - 1));
      next_col = 0;
      cur_row = last_row ? 0 : ((cur_row + 1) & 16'hFFFF);
    end else begin
      next_col = c + 1;
    end
  endtask

  function automatic bit field_ok(string name, logic [SW-1:0] want, logic [SW-1:0] got);
    if (want === got) return 1'b1;
    $error("%s: expected %0h, got %0h", name, want, got);
    return 1'b0;
  endfunction

  task automatic check_pixel();
    filt_pixel_t want;
    bit ok;
    if (expected_pixels.size() == 0) begin
      $error("unexpected result: position %0d row %0d", out_position, out_row_index);
      fail_count++;
    end else begin
      want = expected_pixels.pop_front();
      ok = field_ok("value", want.value, out_value);
      ok &= field_ok("position", SW'(want.position), SW'(out_position));
      ok &= field_ok("row_index", SW'(want.row_index), SW'(out_row_index));
      ok &= field_ok("last_in_run", SW'(want.last_in_run), SW'(out_last_in_run));
      ok &= field_ok("last_of_image", SW'(want.last_of_image), SW'(out_last_of_image));
      if (!ok) fail_count++;
    end
  endtask

  // monitor: results are checked before the same edge's input transfer is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_valid && in_ready;
      if (out_valid && out_ready) check_pixel();
      if (in_valid && in_ready) filter_sample(in_sample);
    end
  end

  // driver: bursts of samples with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (gap_left > 0 || sample_feed.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_sample <= sample_feed.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: long hold-off on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_RANDOM: out_ready <= ($urandom_range(99) < 60);
        default: begin
          out_ready <= READY_BITS[pat_idx];
          pat_idx++;
        end
      endcase
      if (mode_left > 0) begin
        mode_left--;
      end else begin
        ready_mode = ready_mode_t'($urandom_range(2));
        mode_left = $urandom_range(20, 200);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("b3_spline_atrous_row_filter: mismatch");
    $finish;
  end

  function automatic logic [SW-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return SW'($urandom());
  endfunction

  task automatic push_samples(int unsigned n);
    repeat (n) sample_feed.push_back(rand_sample());
  endtask

  task automatic wait_settled(int unsigned extra);
    while (sample_feed.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    case (idx)
      CFG_ROW_LENGTH: begin
        len_reg = data[ROW_LEN_W-1:0];
        next_col = 0;
      end
      CFG_NUM_ROWS: rows_reg = data[NUM_ROWS_W-1:0];
      CFG_STEP_SHIFT: begin
        shift_reg = data[STEP_SHIFT_W-1:0];
        next_col = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(int unsigned len, int unsigned rows, int unsigned shift);
    wait_settled(DRAIN_CYCLES);
    write_reg(CFG_ROW_LENGTH, CFG_DATA_W'(len));
    write_reg(CFG_NUM_ROWS, CFG_DATA_W'(rows));
    write_reg(CFG_STEP_SHIFT, CFG_DATA_W'(shift));
  endtask

  initial begin
    int unsigned len_pick, shift_pick, span, k;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // smallest row, extreme sample values, two rows so the second ends the image
    set_config(5, 2, 0);
    sample_feed.push_back('0);
    sample_feed.push_back('1);
    sample_feed.push_back('0);
    sample_feed.push_back('1);
    sample_feed.push_back('1);
    repeat (5) sample_feed.push_back('1);

    // zero length is raised to the kernel span, zero rows act as one
    set_config(0, 0, 1);
    push_samples(9);

    // ignored register index, then a restart part way through a row
    wait_settled(DRAIN_CYCLES);
    write_reg(CFG_NO_REG, '1);
    push_samples(3);
    set_config(5, 0, 0);
    push_samples(5);

    // receiver holds off while samples keep coming, then the sender pauses
    set_config(5, 3, 0);
    hold_asked++;
    push_samples(15);
    wait_settled(0);
    push_samples(15);

    // three rows leave the row counter at 3, then the row count drops below it
    set_config(12, 8, 1);
    push_samples(36);
    wait_settled(DRAIN_CYCLES);
    write_reg(CFG_NUM_ROWS, CFG_DATA_W'(2));
    push_samples(24);

    // widest tap spacing, full flush of the right border
    set_config(0, 17'h10000, 4);
    push_samples(130);

    // saturated length and step, rows never finished
    set_config(2047, 17'h1FFFF, 7);
    push_samples(40);
    set_config(1024, 1, 0);
    push_samples(30);

    for (k = 0; k < 3; k++) begin
      len_pick = $urandom_range(5, 20);
      shift_pick = $urandom_range(0, 2);
      span = row_span(len_pick, shift_pick);
      set_config(len_pick, $urandom_range(1, 3), shift_pick);
      push_samples(span * ((40 / span > 0) ? 40 / span : 1));
    end

    wait_settled(DRAIN_CYCLES);
    if (fail_count == 0)
      $display("b3_spline_atrous_row_filter: match");
    else
      $display("b3_spline_atrous_row_filter: mismatch");
    $finish;
  end

endmodule

/* files.f */
design/b3atr_pkg.sv
design/b3atr_fifo.sv
design/b3atr_front.sv
design/b3atr_back.sv
design/b3_spline_atrous_row_filter.sv
tb/b3_spline_atrous_row_filter_tb.sv
